// ----- rtl/salwc_pkg.sv -----
// shared constants, types and helpers of the set-associative write-back cache tag store
// used by the controller, the datapath and the top level; no dependencies
package salwc_pkg;

	localparam int SETS        = 256;
	localparam int WAYS        = 4;
	localparam int BLOCK_BYTES = 32;

	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int SET_BITS = $clog2(SETS);
	localparam int TAG_W = 32 - OFF_W - SET_BITS;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	localparam int ADDR_W   = 32;
	localparam int OUT_BITS = 1 + 2 + 1 + 1 + ADDR_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam int IN_W     = ADDR_W;

	typedef logic [WAYS-1:0][WAY_W-1:0] order_t;
	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

	typedef struct packed {
		logic [WAYS-1:0] valid;
		order_t          order;
	} state_row_t;

	// controller to datapath
	typedef struct packed {
		logic             accept;
		logic             commit;
		logic             clr_we;
		logic [IDX_W-1:0] clr_addr;
	} salwc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_stall;
	} salwc_sts_t;

	// reset recency: position p holds way WAYS-1-p
	function automatic state_row_t reset_row();
		state_row_t r;
		r.valid = '0;
		for (int p = 0; p < WAYS; p++) begin
			r.order[p] = WAY_W'(WAYS - 1 - p);
		end
		return r;
	endfunction

endpackage

// ----- rtl/set_assoc_lru_writeback_cache_unit.sv -----
// top level of the set-associative lru write-back cache tag store
// per item, the accept reads the set row into registers, then the commit writes it back
// and loads the result; the commit waits while a held result stalls the output
// a new input transfer is taken only once the previous item has committed
// after reset a sweep over all 256 sets clears valid bits and recency order; no input transfer meanwhile
// depends on salwc_pkg, salwc_ctrl, salwc_dpath
module set_assoc_lru_writeback_cache_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic                         s_tuser,  // func
	input  logic [salwc_pkg::IN_W-1:0]   s_tdata,  // address
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [salwc_pkg::OUT_W-1:0]  m_tdata   // hit, way, fetch_next, writeback, wb address
);
	import salwc_pkg::*;

	salwc_cmd_t cmd;
	salwc_sts_t sts;

	salwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	salwc_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_commit_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(m_tvalid && !m_tready)) else $error("commit while result held");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> !s_tready) else $error("accept not followed by lookup");
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> m_tvalid) else $error("result not presented");
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_we |-> !s_tready && !cmd.commit) else $error("transfer during clear");

endmodule

// ----- rtl/salwc_ctrl.sv -----
// controller of the cache tag store: reset clearing sweep, accept and commit sequencing
// depends on salwc_pkg
module salwc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  salwc_pkg::salwc_sts_t sts,
	output salwc_pkg::salwc_cmd_t cmd
);
	import salwc_pkg::*;

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_LOOKUP} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(SETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (!sts.out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	assign s_tready     = (state_q == ST_IDLE);
	assign cmd.accept   = s_tready && s_tvalid;
	assign cmd.commit   = (state_q == ST_LOOKUP) && !sts.out_stall;
	assign cmd.clr_we   = (state_q == ST_CLEAR);
	assign cmd.clr_addr = clr_q;

endmodule

// ----- rtl/salwc_dpath.sv -----
// datapath of the cache tag store: tag, dirty and state memories, lookup, lru update, result
// depends on salwc_pkg
module salwc_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  salwc_pkg::salwc_cmd_t        cmd,
	output salwc_pkg::salwc_sts_t        sts,
	input  logic                         s_tuser,
	input  logic [salwc_pkg::IN_W-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [salwc_pkg::OUT_W-1:0]  m_tdata
);
	import salwc_pkg::*;

	tag_row_t        tag_mem   [SETS];
	logic [WAYS-1:0] dirty_mem [SETS];
	state_row_t      state_mem [SETS];

	logic [IDX_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic             func_q;
	tag_row_t         tag_rd_q;
	logic [WAYS-1:0]  dirty_rd_q;
	state_row_t       state_rd_q;

	logic [IDX_W-1:0] set_in;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_q;

	assign set_in = (SET_BITS > 0) ? IDX_W'(s_tdata >> OFF_W) : '0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			set_q      <= set_in;
			tag_q      <= TAG_W'(s_tdata >> (OFF_W + SET_BITS));
			func_q     <= s_tuser;
			tag_rd_q   <= tag_mem[set_in];
			dirty_rd_q <= dirty_mem[set_in];
			state_rd_q <= state_mem[set_in];
		end
	end

	// lookup on the registered row
	logic [WAYS-1:0]  hv;
	logic             hit;
	logic             any_inv;
	logic [WAY_W-1:0] hit_way, inv_way, victim, w;
	logic             wb;
	logic [ADDR_W-1:0] wb_addr;
	logic [WAY_W-1:0] pos;
	state_row_t       new_state;
	tag_row_t         new_tags;
	logic [WAYS-1:0]  new_dirty;

	always_comb begin
		hit     = 1'b0;
		any_inv = 1'b0;
		hit_way = '0;
		inv_way = '0;
		for (int i = WAYS - 1; i >= 0; i--) begin
			hv[i] = state_rd_q.valid[i] && (tag_rd_q[i] == tag_q);
			if (hv[i]) begin
				hit     = 1'b1;
				hit_way = WAY_W'(i);
			end
			if (!state_rd_q.valid[i]) begin
				any_inv = 1'b1;
				inv_way = WAY_W'(i);
			end
		end
		victim = state_rd_q.order[WAYS-1];
		priority if (hit) w = hit_way;
		else if (any_inv) w = inv_way;
		else w = victim;

		wb = !hit && !any_inv && dirty_rd_q[victim];
		wb_addr = '0;
		if (wb) begin
			wb_addr = ADDR_W'({tag_rd_q[victim], set_q}) << OFF_W;
			if (SET_BITS == 0) begin
				wb_addr = ADDR_W'(tag_rd_q[victim]) << OFF_W;
			end
		end

		// move w to the front of the recency order
		pos = WAY_W'(WAYS - 1);
		for (int p = WAYS - 1; p >= 0; p--) begin
			if (state_rd_q.order[p] == w) begin
				pos = WAY_W'(p);
			end
		end
		new_state.valid    = state_rd_q.valid;
		new_state.valid[w] = 1'b1;
		new_state.order[0] = w;
		for (int p = 1; p < WAYS; p++) begin
			new_state.order[p] = (WAY_W'(p) <= pos) ? state_rd_q.order[p-1]
				: state_rd_q.order[p];
		end

		new_tags  = tag_rd_q;
		new_dirty = dirty_rd_q;
		if (hit) begin
			if (func_q) begin
				new_dirty[w] = 1'b1;
			end
		end else begin
			new_tags[w]  = tag_q;
			new_dirty[w] = func_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			state_mem[cmd.clr_addr] <= reset_row();
		end else if (cmd.commit) begin
			state_mem[set_q] <= new_state;
		end
		if (cmd.commit) begin
			tag_mem[set_q]   <= new_tags;
			dirty_mem[set_q] <= new_dirty;
			out_q <= OUT_W'({wb_addr, wb, !hit, 2'(w), hit});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_q;
	assign sts.out_stall = out_valid_q && !m_tready;

endmodule

// ----- tb/set_assoc_lru_writeback_cache_unit_tb.sv -----
// testbench of the set-associative lru write-back cache tag store
// predicts each lookup result with its own tag, valid, dirty and recency model
// depends on salwc_pkg and set_assoc_lru_writeback_cache_unit
module set_assoc_lru_writeback_cache_unit_tb;
	import salwc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        hit;
		logic [1:0]  way;
		logic        fetch_next;
		logic        writeback;
		logic [31:0] wb_addr;
	} lookup_t;

	class cache_scoreboard;
		logic [31:0] tags [SETS][WAYS];
		bit          valid [SETS][WAYS];
		bit          dirty [SETS][WAYS];
		int          order [SETS][WAYS];
		lookup_t     pending [$];
		int          mismatches;

		function void clear();
			for (int s = 0; s < SETS; s++) begin
				for (int p = 0; p < WAYS; p++) begin
					tags[s][p] = '0;
					valid[s][p] = 0;
					dirty[s][p] = 0;
					order[s][p] = WAYS - 1 - p;
				end
			end
			pending.delete();
			mismatches = 0;
		endfunction

		// works out the lookup result and updates the model state
		function void note_request(bit is_write, logic [31:0] addr);
			int set_i;
			logic [31:0] tag;
			int w;
			int pos;
			bit found;
			lookup_t r;
			set_i = (addr >> OFF_W) & (SETS - 1);
			tag = addr >> (OFF_W + SET_BITS);
			r = '0;
			w = 0;
			for (int i = 0; i < WAYS; i++) begin
				if (!r.hit && valid[set_i][i] && tags[set_i][i] == tag) begin
					r.hit = 1;
					w = i;
				end
			end
			if (r.hit) begin
				if (is_write) dirty[set_i][w] = 1;
			end else begin
				found = 0;
				for (int i = 0; i < WAYS; i++) begin
					if (!found && !valid[set_i][i]) begin
						found = 1;
						w = i;
					end
				end
				if (!found) begin
					w = order[set_i][WAYS-1];
					if (dirty[set_i][w]) begin
						r.writeback = 1;
						r.wb_addr = (tags[set_i][w] << (OFF_W + SET_BITS)) | (set_i << OFF_W);
					end
				end
				tags[set_i][w] = tag;
				valid[set_i][w] = 1;
				dirty[set_i][w] = is_write;
				r.fetch_next = 1;
			end
			pos = WAYS - 1;
			for (int p = WAYS - 1; p >= 0; p--) begin
				if (order[set_i][p] == w) pos = p;
			end
			for (int p = pos; p > 0; p--) order[set_i][p] = order[set_i][p-1];
			order[set_i][0] = w;
			r.way = w[1:0];
			pending.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] data);
			lookup_t got;
			lookup_t want;
			got.hit = data[0];
			got.way = data[2:1];
			got.fetch_next = data[3];
			got.writeback = data[4];
			got.wb_addr = data[36:5];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", data);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected hit=%b way=%0d fetch=%b wb=%b wba=%h,",
						" got hit=%b way=%0d fetch=%b wb=%b wba=%h"},
						want.hit, want.way, want.fetch_next, want.writeback, want.wb_addr,
						got.hit, got.way, got.fetch_next, got.writeback, got.wb_addr);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic s_tuser;
	logic [IN_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;

	cache_scoreboard sb;
	bit quiet;
	bit hold_sink;
	int stall_left;

	set_assoc_lru_writeback_cache_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	initial begin
		#50ms;
		$display("set_assoc_lru_writeback_cache_unit test failed");
		$finish;
	end

	// offers one request and holds it until the transfer
	task automatic send_request(bit is_write, logic [31:0] addr);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= is_write;
		s_tdata <= addr;
		do @(posedge clk); while (!s_tready);
		sb.note_request(is_write, addr);
	endtask

	// address within a small pool of tags and sets so that hits and evictions are common
	function automatic logic [31:0] pool_address();
		logic [31:0] tag;
		logic [31:0] set_i;
		tag = $urandom_range(0, 5);
		if ($urandom_range(0, 1)) tag = tag ^ 32'h7_FFF8;
		set_i = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) set_i = set_i + 252;
		return (tag << (OFF_W + SET_BITS)) | (set_i << OFF_W) | $urandom_range(0, BLOCK_BYTES - 1);
	endfunction

	// sink: random stall bursts, one long hold-off, none at the end
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (stall_left > 0) stall_left--;
			else if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 8);
			m_tready <= !hold_sink && (stall_left == 0);
		end
	end

	initial begin
		int waited;
		sb = new();
		sb.clear();
		quiet = 0;
		hold_sink = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = 1'b0;
		s_tdata = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed: extremes, fill a set past its ways, dirty eviction, hits both kinds
		send_request(0, 32'h0000_0000);
		send_request(1, 32'hFFFF_FFFF);
		send_request(1, 32'hFFFF_FFE0);
		send_request(0, 32'hFFFF_FFFF);
		for (int i = 1; i <= 5; i++) send_request(1, i << (OFF_W + SET_BITS));
		for (int i = 0; i < 6; i++) send_request(i[0], i << (OFF_W + SET_BITS));
		send_request(0, 32'hAAAA_AAAA);
		send_request(1, 32'h5555_5555);
		send_request(0, 32'hAAAA_AAAA);
		send_request(1, 32'h5555_5555);
		// long receiver hold-off while requests keep coming
		fork
			begin
				hold_sink = 1;
				repeat (200) @(posedge clk);
				hold_sink = 0;
			end
			for (int i = 0; i < 20; i++) send_request($urandom_range(0, 1), pool_address());
		join
		for (int n = 0; n < 1430; n++) begin
			if (n == 1200) quiet = 1;
			if ($urandom_range(0, 9) == 0) send_request($urandom_range(0, 1), $urandom());
			else send_request($urandom_range(0, 1), pool_address());
		end
		s_tvalid <= 1'b0;
		waited = 0;
		while (sb.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("set_assoc_lru_writeback_cache_unit test passed");
		end else begin
			$display("set_assoc_lru_writeback_cache_unit test failed");
		end
		$finish;
	end

endmodule
